// ===== hdl/sorted_key_value_insert_table_macros.svh =====
// Assertion macros shared by the table RTL.
`ifndef SORTED_KEY_VALUE_INSERT_TABLE_MACROS_SVH
`define SORTED_KEY_VALUE_INSERT_TABLE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SKVI_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sorted table check failed");

// Next-cycle implication, checked outside reset.
`define SKVI_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sorted table check failed");

`endif

// ===== hdl/skvi_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package skvi_pkg;

   localparam int CAPACITY = 64;
   localparam int KEY_W    = 31;
   localparam int ID_W     = 31;
   localparam int COUNT_W  = $clog2(CAPACITY + 1);

   typedef enum logic {
      CMD_INSERT = 1'b0,
      CMD_DRAIN  = 1'b1
   } command_type;

   typedef enum logic [1:0] {
      STATUS_ENTRY = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   typedef enum logic {
      ST_IDLE  = 1'b0,
      ST_DRAIN = 1'b1
   } state_type;

   typedef struct packed {
      command_type       command;
      logic [KEY_W-1:0]  sort_key;
      logic [ID_W-1:0]   record_id;
   } req_type;

   typedef struct packed {
      logic [KEY_W-1:0]  out_key;
      logic [ID_W-1:0]   out_id;
      status_type        status;
      logic              last;
   } rsp_type;

   // Broadcast to every cell of the chain.
   typedef struct packed {
      logic              insert;
      logic              shift;
      logic [KEY_W-1:0]  new_key;
      logic [ID_W-1:0]   new_id;
   } cell_ctrl_type;

endpackage

`default_nettype wire

// ===== hdl/skvi_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

module skvi_cell (
   input  wire logic                          clock,
   input  wire skvi_pkg::cell_ctrl_type       ctrl,
   input  wire logic                          occupied,
   input  wire logic                          left_keep,
   input  wire logic [skvi_pkg::KEY_W-1:0]    left_key,
   input  wire logic [skvi_pkg::ID_W-1:0]     left_id,
   input  wire logic [skvi_pkg::KEY_W-1:0]    right_key,
   input  wire logic [skvi_pkg::ID_W-1:0]     right_id,
   output logic                               keep,
   output logic [skvi_pkg::KEY_W-1:0]         key,
   output logic [skvi_pkg::ID_W-1:0]          id
);

   logic [skvi_pkg::KEY_W-1:0] key_ff, key_in;
   logic [skvi_pkg::ID_W-1:0]  id_ff, id_in;

   // Stay put while the stored key is strictly smaller than the new one.
   assign keep = occupied && (key_ff < ctrl.new_key);

   always_comb begin
      key_in = key_ff;
      id_in  = id_ff;
      if (ctrl.insert) begin
         if (keep) begin
            key_in = key_ff;
            id_in  = id_ff;
         end else if (left_keep) begin
            key_in = ctrl.new_key;
            id_in  = ctrl.new_id;
         end else begin
            key_in = left_key;
            id_in  = left_id;
         end
      end else if (ctrl.shift) begin
         key_in = right_key;
         id_in  = right_id;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
      id_ff  <= id_in;
   end

   assign key = key_ff;
   assign id  = id_ff;

endmodule

`default_nettype wire

// ===== hdl/sorted_key_value_insert_table.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Sorted key/value table: a chain of CAPACITY cells keeps (key, id) pairs in
// ascending key order, newest first among equal keys. Inserts may follow
// each other in every cycle while the request side does not stall; each
// cell compares its key with the new one and holds, loads the new pair or
// takes its left neighbor's pair. A drain stalls the request side until
// all stored entries are out: the chain shifts left one entry per cycle
// while the result side does not stall, into the result register, the last
// entry flagged, then the table is empty. A drain of an empty table or an
// insert into a full one answers with a single status transaction.
`include "sorted_key_value_insert_table_macros.svh"

module sorted_key_value_insert_table (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire skvi_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output skvi_pkg::rsp_type      rsp_data
);

   localparam int N = skvi_pkg::CAPACITY;
   localparam logic [skvi_pkg::COUNT_W-1:0] CAP_C = skvi_pkg::COUNT_W'(N);
   localparam logic [skvi_pkg::COUNT_W-1:0] ONE_C = skvi_pkg::COUNT_W'(1);

   skvi_pkg::state_type            state_ff, state_in;
   logic [skvi_pkg::COUNT_W-1:0]   count_ff, count_in;
   logic [skvi_pkg::COUNT_W-1:0]   remain_ff, remain_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   skvi_pkg::rsp_type              rsp_ff, rsp_in;

   skvi_pkg::cell_ctrl_type        ctrl;
   logic                           req_accept, do_insert, full_insert, drain_accept;
   logic                           slot_free, emit;

   logic [N-1:0]                   keep_w;
   logic [N-1:0]                   occ_w;
   logic [skvi_pkg::KEY_W-1:0]     key_w [N];
   logic [skvi_pkg::ID_W-1:0]      id_w  [N];

   assign req_stall    = (state_ff == skvi_pkg::ST_DRAIN) || (rsp_valid_ff && rsp_stall);
   assign req_accept   = req_valid && !req_stall;
   assign slot_free    = !rsp_valid_ff || !rsp_stall;
   assign do_insert    = req_accept && (req_data.command == skvi_pkg::CMD_INSERT)
                         && (count_ff < CAP_C);
   assign full_insert  = req_accept && (req_data.command == skvi_pkg::CMD_INSERT)
                         && (count_ff >= CAP_C);
   assign drain_accept = req_accept && (req_data.command == skvi_pkg::CMD_DRAIN);
   assign emit         = (state_ff == skvi_pkg::ST_DRAIN) && slot_free;

   assign ctrl.insert  = do_insert;
   assign ctrl.shift   = emit;
   assign ctrl.new_key = req_data.sort_key;
   assign ctrl.new_id  = req_data.record_id;

   for (genvar i = 0; i < N; i++) begin : g_cell
      assign occ_w[i] = skvi_pkg::COUNT_W'(i) < count_ff;
      skvi_cell u_cell (
         .clock     (clock),
         .ctrl      (ctrl),
         .occupied  (occ_w[i]),
         .left_keep ((i == 0) ? 1'b1 : keep_w[(i == 0) ? 0 : i - 1]),
         .left_key  (key_w[(i == 0) ? 0 : i - 1]),
         .left_id   (id_w[(i == 0) ? 0 : i - 1]),
         .right_key (key_w[(i == N - 1) ? i : i + 1]),
         .right_id  (id_w[(i == N - 1) ? i : i + 1]),
         .keep      (keep_w[i]),
         .key       (key_w[i]),
         .id        (id_w[i])
      );
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      remain_in    = remain_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      unique case (state_ff)
         skvi_pkg::ST_IDLE: begin
            if (do_insert) begin
               count_in = count_ff + ONE_C;
            end
            if (full_insert) begin
               rsp_valid_in   = 1'b1;
               rsp_in.out_key = '0;
               rsp_in.out_id  = '0;
               rsp_in.status  = skvi_pkg::STATUS_FULL;
               rsp_in.last    = 1'b1;
            end
            if (drain_accept) begin
               if (count_ff == '0) begin
                  rsp_valid_in   = 1'b1;
                  rsp_in.out_key = '0;
                  rsp_in.out_id  = '0;
                  rsp_in.status  = skvi_pkg::STATUS_EMPTY;
                  rsp_in.last    = 1'b1;
               end else begin
                  state_in  = skvi_pkg::ST_DRAIN;
                  remain_in = count_ff;
               end
            end
         end
         skvi_pkg::ST_DRAIN: begin
            // Advance the chain one entry per free result slot.
            if (emit) begin
               rsp_valid_in   = 1'b1;
               rsp_in.out_key = key_w[0];
               rsp_in.out_id  = id_w[0];
               rsp_in.status  = skvi_pkg::STATUS_ENTRY;
               rsp_in.last    = (remain_ff == ONE_C);
               remain_in      = remain_ff - ONE_C;
               if (remain_ff == ONE_C) begin
                  state_in = skvi_pkg::ST_IDLE;
                  count_in = '0;
               end
            end
         end
         default: begin
            state_in = skvi_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= skvi_pkg::ST_IDLE;
         count_ff     <= '0;
         remain_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         remain_ff    <= remain_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `SKVI_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_ff <= CAP_C)
   `SKVI_ASSERT_NOW(a_drain_remain, clock, reset, state_ff == skvi_pkg::ST_DRAIN,
      (remain_ff != '0) && (remain_ff <= count_ff))
   `SKVI_ASSERT_NOW(a_status_last, clock, reset,
      rsp_valid_ff && (rsp_ff.status != skvi_pkg::STATUS_ENTRY), rsp_ff.last)
   `SKVI_ASSERT_NEXT(a_drain_start, clock, reset, drain_accept && (count_ff != '0),
      state_ff == skvi_pkg::ST_DRAIN)

endmodule

`default_nettype wire
